>>> rtl/core/i4p_pkg.sv
// Shared types, mode codes and filter functions for the 4x4 intra predictor.
// No dependencies; imported by i4p_predict and intra4x4_predictor_core.
package i4p_pkg;

	typedef logic [7:0] sample_t;

	// Prediction mode codes; 9..15 are unknown and flag an error
	localparam logic [3:0] MODE_VERT = 4'd0;
	localparam logic [3:0] MODE_HORZ = 4'd1;
	localparam logic [3:0] MODE_DC   = 4'd2;
	localparam logic [3:0] MODE_DDL  = 4'd3;
	localparam logic [3:0] MODE_DDR  = 4'd4;
	localparam logic [3:0] MODE_VR   = 4'd5;
	localparam logic [3:0] MODE_HD   = 4'd6;
	localparam logic [3:0] MODE_VL   = 4'd7;
	localparam logic [3:0] MODE_HU   = 4'd8;

	localparam sample_t DC_DEFAULT = 8'd128;

	typedef struct packed {
		logic topright_ok;
		logic corner_ok;
		logic top_ok;
		logic left_ok;
	} avail_t;

	typedef struct packed {
		logic [3:0]  mode;
		avail_t      avail;
		sample_t     corner;
		logic [63:0] top;
		logic [31:0] left;
	} item_t;

	typedef struct packed {
		logic         status;
		logic [127:0] rows;   // row0 in bits 31:0, row3 in bits 127:96
	} res_t;

	// 2-tap rounding average
	function automatic sample_t avg2(input sample_t a, input sample_t b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + 9'd1;
		return s[8:1];
	endfunction

	// 3-tap (1,2,1) rounding filter
	function automatic sample_t avg3(input sample_t a, input sample_t b, input sample_t c);
		logic [9:0] s;
		s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
		return s[9:2];
	endfunction

endpackage

>>> rtl/core/intra4x4_predictor_core.sv
// Top level of the 4x4 luma intra predictor: input register, predictor, result register.
// Depends on i4p_pkg and i4p_predict.
//
//  channel   dir  payload                                         handshake
//  s_axis    in   tdata: left, top, corner; tuser: mode, flags     tvalid/tready
//  m_axis    out  tdata: row0..row3; tuser: status                 tvalid/tready
//
// One block per cycle sustained while m_axis_tready stays high. A block accepted on s_axis
// is registered in _s1, predicted combinationally and registered in _s2, then presented on m_axis
// (input register _s1, prediction logic, result register _s2).
// arst_n clears both valid bits; payload registers are not reset.
// A stall on m_axis holds _s2; _s1 keeps filling, so s_axis_tready drops
// only when both stages hold data and m_axis_tready is low.
module intra4x4_predictor_core
	import i4p_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // left_samples[31:0], top_samples[95:32],
	                                    // corner_sample[103:96]
	input  logic [7:0]   s_axis_tuser,  // pred_mode[3:0], left_ok[4], top_ok[5],
	                                    // corner_ok[6], topright_ok[7]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // row0[31:0], row1[63:32], row2[95:64],
	                                    // row3[127:96]
	output logic [0:0]   m_axis_tuser   // status[0]
);

	item_t item_s1;
	logic  vld_s1;
	res_t  res_s2;
	logic  vld_s2;
	res_t  res_comb;
	logic  adv_s2;   // _s1 moves into _s2 this cycle
	logic  in_xfer;

	// Result stage frees up when empty or when its transfer completes
	assign adv_s2        = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || !vld_s2 || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.left         <= s_axis_tdata[31:0];
			item_s1.top          <= s_axis_tdata[95:32];
			item_s1.corner       <= s_axis_tdata[103:96];
			item_s1.mode         <= s_axis_tuser[3:0];
			item_s1.avail.left_ok     <= s_axis_tuser[4];
			item_s1.avail.top_ok      <= s_axis_tuser[5];
			item_s1.avail.corner_ok   <= s_axis_tuser[6];
			item_s1.avail.topright_ok <= s_axis_tuser[7];
		end
	end

	i4p_predict u_predict (
		.item (item_s1),
		.res  (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_axis_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_comb;
		end
	end

	assign m_axis_tvalid   = vld_s2;
	assign m_axis_tdata    = res_s2.rows;
	assign m_axis_tuser[0] = res_s2.status;

`ifndef SYNTH
	// An error result always carries zero rows
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 128'd0))
		else $error("error result with nonzero rows");

	// An accepted block is held in the input stage on the next cycle
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> vld_s1)
		else $error("accepted block lost at input stage");

	// A block moving out of the input stage is presented on m_axis next cycle
	a_out_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> m_axis_tvalid)
		else $error("block lost between stages");

	// Backpressure only with both stages full and the output stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (vld_s1 && vld_s2 && !m_axis_tready))
		else $error("input stalled without cause");
`endif

endmodule

>>> rtl/core/i4p_predict.sv
// Combinational 4x4 luma prediction: neighbor setup, DC average, 16 filtered samples.
// Depends on i4p_pkg.
module i4p_predict
	import i4p_pkg::*;
(
	input  item_t item,
	output res_t  res
);

	sample_t     t [9];   // t[0] corner, t[1..8] A..H
	sample_t     l [5];   // l[0] corner, l[1..4] I..L
	logic [9:0]  sum_t;
	logic [9:0]  sum_l;
	logic [10:0] sum_tl;
	logic [9:0]  sum_t_r;
	logic [9:0]  sum_l_r;
	sample_t     dc;
	logic        err;

	always_comb begin
		t[0] = item.corner;
		l[0] = item.corner;
		for (int i = 0; i < 4; i++) begin
			t[i + 1] = item.top[8 * i +: 8];
			l[i + 1] = item.left[8 * i +: 8];
		end
		for (int i = 4; i < 8; i++) begin
			t[i + 1] = item.avail.topright_ok ? item.top[8 * i +: 8] : item.top[31:24];
		end
	end

	// DC: average of what is available, 128 when nothing is
	always_comb begin
		sum_t   = {2'b00, t[1]} + {2'b00, t[2]} + {2'b00, t[3]} + {2'b00, t[4]};
		sum_l   = {2'b00, l[1]} + {2'b00, l[2]} + {2'b00, l[3]} + {2'b00, l[4]};
		sum_tl  = {1'b0, sum_t} + {1'b0, sum_l} + 11'd4;
		sum_t_r = sum_t + 10'd2;
		sum_l_r = sum_l + 10'd2;
		if (item.avail.top_ok && item.avail.left_ok) begin
			dc = sum_tl[10:3];
		end else if (item.avail.top_ok) begin
			dc = sum_t_r[9:2];
		end else if (item.avail.left_ok) begin
			dc = sum_l_r[9:2];
		end else begin
			dc = DC_DEFAULT;
		end
	end

	always_comb begin
		unique case (item.mode)
			MODE_VERT, MODE_DDL, MODE_VL: err = !item.avail.top_ok;
			MODE_HORZ, MODE_HU:           err = !item.avail.left_ok;
			MODE_DC:                      err = 1'b0;
			MODE_DDR, MODE_VR, MODE_HD:
				err = !(item.avail.top_ok && item.avail.left_ok && item.avail.corner_ok);
			default:                      err = 1'b1;
		endcase
	end

	// Per-sample filter selection; all indices fold to constants per position
	always_comb begin
		int      z;
		int      k;
		sample_t v;
		res.status = err;
		res.rows   = '0;
		for (int y = 0; y < 4; y++) begin
			for (int x = 0; x < 4; x++) begin
				z = 0;
				k = 0;
				case (item.mode)
					MODE_VERT: v = t[x + 1];
					MODE_HORZ: v = l[y + 1];
					MODE_DC:   v = dc;
					MODE_DDL: begin
						if (x == 3 && y == 3) v = avg3(t[7], t[8], t[8]);
						else v = avg3(t[x + y + 1], t[x + y + 2], t[x + y + 3]);
					end
					MODE_DDR: begin
						if (x > y) begin
							k = x - y;
							v = avg3(t[k - 1], t[k], t[k + 1]);
						end else if (x < y) begin
							k = y - x;
							v = avg3(l[k - 1], l[k], l[k + 1]);
						end else begin
							v = avg3(t[1], t[0], l[1]);
						end
					end
					MODE_VR: begin
						z = 2 * x - y;
						if (z >= 0) begin
							k = x - (y >> 1);
							if ((z & 1) == 0) v = avg2(t[k], t[k + 1]);
							else v = avg3(t[k - 1], t[k], t[k + 1]);
						end else if (z == -1) begin
							v = avg3(l[1], l[0], t[1]);
						end else begin
							v = avg3(l[y], l[y - 1], l[y - 2]);
						end
					end
					MODE_HD: begin
						z = 2 * y - x;
						if (z >= 0) begin
							k = y - (x >> 1);
							if ((z & 1) == 0) v = avg2(l[k], l[k + 1]);
							else v = avg3(l[k - 1], l[k], l[k + 1]);
						end else if (z == -1) begin
							v = avg3(l[1], l[0], t[1]);
						end else begin
							v = avg3(t[x], t[x - 1], t[x - 2]);
						end
					end
					MODE_VL: begin
						k = x + (y >> 1);
						if ((y & 1) == 0) v = avg2(t[k + 1], t[k + 2]);
						else v = avg3(t[k + 1], t[k + 2], t[k + 3]);
					end
					MODE_HU: begin
						z = x + 2 * y;
						k = y + (x >> 1);
						if (z > 5) v = l[4];
						else if (z == 5) v = avg3(l[3], l[4], l[4]);
						else if ((z & 1) == 0) v = avg2(l[k + 1], l[k + 2]);
						else v = avg3(l[k + 1], l[k + 2], l[k + 3]);
					end
					default: v = '0;
				endcase
				res.rows[32 * y + 8 * x +: 8] = err ? 8'd0 : v;
			end
		end
	end

endmodule
